// File: hw/rtl/assert_macros.svh
// assertion macros shared by the checker files
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every clock edge outside reset
`define CHK_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// implication checked in the cycle after the antecedent
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// File: hw/rtl/ilha_pkg.sv
// shared constants and types for the implicit-list heap allocator
// no dependencies
package ilha_pkg;
    localparam int unsigned HeapBytesDefault = 65536;
    localparam int unsigned ReqW  = 17;
    localparam int unsigned AddrW = 16;
    localparam int unsigned SizeW = 17;

    typedef enum logic [1:0] {
        ACT_INIT    = 2'd0,
        ACT_ALLOC   = 2'd1,
        ACT_RELEASE = 2'd2,
        ACT_NOP     = 2'd3
    } t_action;

    // header entry: size in upper bits, used flag in bit 0
    typedef struct packed {
        logic [SizeW-1:0] size;
        logic             used;
    } t_hdr;
endpackage

// File: hw/rtl/ilha_ram.sv
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module ilha_ram #(
    parameter int unsigned Width = 18,
    parameter int unsigned Depth = 8192
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: hw/rtl/implicit_list_heap_allocator.sv
// implicit-list heap allocator, best fit with early stop on a close fit; chunk headers live in one ram
// init, no-op and an ignored release strobe straight from idle; a release reads the header and
// writes it back; allocate on an untouched heap goes straight to carve, else it walks the headers
// (read, wait, evaluate each) until an early stop or the end, plus a second carve step on a split
// throughput: one transaction at a time, busy high until the result strobe
// reset: synchronous active-low i_rst_n clears length and touched flag; header ram not cleared
module implicit_list_heap_allocator #(
    parameter int unsigned HEAP_BYTES = ilha_pkg::HeapBytesDefault
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [1:0]              i_action,
    input  logic [ilha_pkg::ReqW-1:0]  i_request_size,
    input  logic [ilha_pkg::AddrW-1:0] i_release_addr,
    output logic                    o_valid,
    output logic [ilha_pkg::AddrW-1:0] o_payload_addr,
    output logic                    o_ok
);
    import ilha_pkg::*;

    localparam int unsigned Slots = HEAP_BYTES / 8;
    localparam int unsigned SlotW = $clog2(Slots);
    localparam int unsigned LenW  = $clog2(HEAP_BYTES + 1);
    localparam int unsigned HdrW  = (LenW > ReqW) ? LenW : ReqW;
    localparam int unsigned CW    = HdrW + 2;   // headroom for walk sums

    typedef struct packed {
        logic [HdrW-1:0] size;
        logic            used;
    } t_slot;

    typedef enum logic [2:0] {
        ST_IDLE, ST_READ, ST_WAIT, ST_EVAL, ST_CARVE, ST_CARVE2, ST_DONE
    } t_state;

    t_state r_state;
    logic [LenW-1:0] r_len;
    logic            r_touched;
    logic [CW-1:0]   r_c, r_prev, r_best, r_want, r_limit;
    logic [CW-1:0]   r_bsize, r_whole;
    logic            r_have_prev, r_prev_free, r_found;
    logic            r_ovalid, r_ok;
    logic [AddrW-1:0] r_pay;

    logic             we;
    logic [SlotW-1:0] waddr, raddr;
    t_slot            wdata, rdata;
    logic [HdrW:0]    rd_raw;

    ilha_ram #(.Width(HdrW + 1), .Depth(Slots)) u_hdr_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rd_raw)
    );
    assign rdata = t_slot'(rd_raw);

    function automatic logic [CW-1:0] rup8(input logic [CW-1:0] x);
        logic [CW-1:0] y;
        y = x + CW'(7);
        return {y[CW-1:3], 3'b000};
    endfunction

    // combinational walk step values
    logic [CW-1:0] s_cur, s_merged, c_next, end_c, next_c, pad_c, app_c, app_end;
    always_comb begin
        s_cur    = CW'(rdata.size);
        s_merged = (r_c - r_prev) + s_cur;
        c_next   = rup8(r_c + s_cur + CW'(9));
        end_c    = r_best + CW'(9) + r_want;
        next_c   = rup8(end_c);
        pad_c    = next_c - end_c;
        app_c    = rup8(CW'(r_len));
        app_end  = app_c + r_want + CW'(9);
    end

    assign raddr = r_c[SlotW+2:3];
    assign busy  = (r_state != ST_IDLE);
    assign o_valid = r_ovalid;
    assign o_payload_addr = r_pay;
    assign o_ok = r_ok;

    // ram write control
    always_comb begin
        we    = 1'b0;
        waddr = r_c[SlotW+2:3];
        wdata = '{size: rdata.size, used: 1'b0};
        case (r_state)
            ST_EVAL: begin
                if (!rdata.used && r_have_prev && r_prev_free) begin
                    we    = 1'b1;
                    waddr = r_prev[SlotW+2:3];
                    wdata = '{size: HdrW'(s_merged), used: 1'b0};
                end
            end
            ST_CARVE: begin
                if (r_found) begin
                    we    = 1'b1;
                    waddr = r_best[SlotW+2:3];
                    if (r_whole > r_want + CW'(18) + pad_c) begin
                        wdata = '{size: HdrW'(r_want), used: 1'b1};
                    end else begin
                        wdata = '{size: HdrW'(r_whole), used: 1'b1};
                    end
                end else if (app_end <= CW'(HEAP_BYTES)) begin
                    // new chunk at the heap end
                    we    = 1'b1;
                    waddr = app_c[SlotW+2:3];
                    wdata = '{size: HdrW'(r_want), used: 1'b1};
                end
            end
            ST_CARVE2: begin
                we    = 1'b1;
                waddr = next_c[SlotW+2:3];
                wdata = '{size: HdrW'(r_whole - r_want - CW'(9) - pad_c), used: 1'b0};
            end
            ST_DONE: begin
                // release: write back size with used cleared
                we    = 1'b1;
                waddr = r_c[SlotW+2:3];
                wdata = '{size: rdata.size, used: 1'b0};
            end
            default: ;
        endcase
    end

    logic r_rel;    // pending release write in ST_DONE
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_len     <= '0;
            r_touched <= 1'b0;
            r_ovalid  <= 1'b0;
            r_ok      <= 1'b0;
            r_pay     <= '0;
            r_rel     <= 1'b0;
        end else begin
            r_ovalid <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (start) begin
                        r_pay <= '0;
                        r_ok  <= 1'b0;
                        r_rel <= 1'b0;
                        r_want  <= CW'(i_request_size);
                        r_limit <= CW'(i_request_size) + CW'(i_request_size[ReqW-1:1]);
                        r_c <= '0;
                        r_have_prev <= 1'b0;
                        r_prev_free <= 1'b0;
                        r_found <= 1'b0;
                        r_bsize <= '1;
                        r_best  <= '0;
                        case (t_action'(i_action))
                            ACT_INIT: begin
                                r_touched <= 1'b0;
                                r_ovalid  <= 1'b1;
                            end
                            ACT_ALLOC: begin
                                r_state <= r_touched ? ST_READ : ST_CARVE;
                            end
                            ACT_RELEASE: begin
                                if (i_release_addr != '0 && r_touched
                                    && (CW'(i_release_addr) + CW'(1) < CW'(r_len))
                                    && i_release_addr[2:0] == 3'b000) begin
                                    r_c   <= CW'(i_release_addr) - CW'(8);
                                    r_rel <= 1'b1;
                                    r_ok  <= 1'b1;
                                    r_state <= ST_WAIT;
                                end else begin
                                    r_ovalid <= 1'b1;
                                end
                            end
                            default: r_ovalid <= 1'b1;
                        endcase
                    end
                end
                ST_READ: begin
                    if (r_c + CW'(1) < CW'(r_len)) r_state <= ST_WAIT;
                    else r_state <= ST_CARVE;
                end
                ST_WAIT: r_state <= r_rel ? ST_DONE : ST_EVAL;
                ST_EVAL: begin
                    r_state <= ST_READ;
                    if (!rdata.used) begin
                        if (r_have_prev && r_prev_free) begin
                            // merge into predecessor, continue past the merged chunk
                            r_c <= c_next;
                            if (r_found && r_prev == r_best) r_whole <= s_merged;
                        end else begin
                            if (s_cur >= r_want && s_cur < r_bsize) begin
                                r_best  <= r_c;
                                r_bsize <= s_cur;
                                r_whole <= s_cur;
                                r_found <= 1'b1;
                                if (s_cur <= r_limit) r_state <= ST_CARVE;
                            end
                            r_prev <= r_c;
                            r_prev_free <= 1'b1;
                            r_have_prev <= 1'b1;
                            r_c <= c_next;
                        end
                    end else begin
                        r_prev <= r_c;
                        r_prev_free <= 1'b0;
                        r_have_prev <= 1'b1;
                        r_c <= c_next;
                    end
                end
                ST_CARVE: begin
                    if (r_found) begin
                        r_touched <= 1'b1;
                        r_ok  <= 1'b1;
                        r_pay <= AddrW'(r_best + CW'(8));
                        if (r_whole > r_want + CW'(18) + pad_c) r_state <= ST_CARVE2;
                        else begin
                            r_state  <= ST_IDLE;
                            r_ovalid <= 1'b1;
                        end
                    end else if (app_end <= CW'(HEAP_BYTES)) begin
                        r_touched <= 1'b1;
                        r_ok  <= 1'b1;
                        r_pay <= AddrW'(app_c + CW'(8));
                        r_len <= LenW'(app_end);
                        r_state  <= ST_IDLE;
                        r_ovalid <= 1'b1;
                    end else begin
                        r_state  <= ST_IDLE;
                        r_ovalid <= 1'b1;
                    end
                end
                ST_CARVE2: begin
                    r_state  <= ST_IDLE;
                    r_ovalid <= 1'b1;
                end
                ST_DONE: begin
                    r_state  <= ST_IDLE;
                    r_ovalid <= 1'b1;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end
endmodule

// File: hw/rtl/ilha_checker.sv
// port-level checker for the heap allocator, bound to the allocator module
// depends on assert_macros.svh and ilha_pkg
`include "assert_macros.svh"
module ilha_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       start,
    input logic                       busy,
    input logic                       o_valid,
    input logic [ilha_pkg::AddrW-1:0] o_payload_addr,
    input logic                       o_ok
);
    `CHK_IMPL(a_fail_zero, i_clk, i_rst_n, o_valid && !o_ok, o_payload_addr == '0, "fail addr")
    `CHK_IMPL(a_pay_align, i_clk, i_rst_n, o_valid, o_payload_addr[2:0] == 3'd0, "unaligned")
    `CHK_NEXT(a_take_busy, i_clk, i_rst_n, start && !busy, busy || o_valid, "dropped")
    `CHK_IMPL(a_strobe_idle, i_clk, i_rst_n, o_valid, !busy, "strobe while busy")
endmodule

bind implicit_list_heap_allocator ilha_checker u_chk (.*);

// File: dv/ilha_checker.sv
`timescale 1ns / 100ps
// checker for the implicit-list heap allocator: predicts each transaction and compares results
// depends on ilha_pkg
module ilha_scoreboard #(
    parameter int unsigned HEAP_BYTES = ilha_pkg::HeapBytesDefault
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic                           i_busy,
    input  logic [1:0]                     i_action,
    input  logic [ilha_pkg::ReqW-1:0]      i_request_size,
    input  logic [ilha_pkg::AddrW-1:0]     i_release_addr,
    input  logic                           i_valid,
    input  logic [ilha_pkg::AddrW-1:0]     i_payload_addr,
    input  logic                           i_ok,
    output int unsigned                    o_fail_count,
    output int unsigned                    o_pending
);
    import ilha_pkg::*;

    localparam int unsigned SlotCount = HEAP_BYTES / 8;

    typedef struct packed {
        logic [AddrW-1:0] addr;
        logic             ok;
    } t_answer;

    t_hdr        hdr_mem [SlotCount];
    int unsigned heap_len;
    bit          touched;
    t_answer     answer_q[$];

    function automatic int unsigned rnd8(int unsigned x);
        return (x + 7) & ~32'd7;
    endfunction

    function automatic int unsigned size_at(int unsigned c);
        return (c / 8 < SlotCount) ? int'(hdr_mem[c / 8].size) : 0;
    endfunction

    function automatic bit used_at(int unsigned c);
        return (c / 8 < SlotCount) ? hdr_mem[c / 8].used : 1'b0;
    endfunction

    function automatic void put_hdr(int unsigned c, int unsigned sz, bit used);
        if (c / 8 < SlotCount) begin
            hdr_mem[c / 8].size = sz[SizeW-1:0];
            hdr_mem[c / 8].used = used;
        end
    endfunction

    // best-fit walk with early stop on a close fit and coalescing of adjacent free chunks
    function automatic bit find_fit(int unsigned want, output int unsigned where);
        int unsigned c, prev, best, best_sz, s, lim;
        bit have_prev, prev_free, found;
        c = 0; prev = 0; best = 0; best_sz = 32'hFFFF_FFFF;
        have_prev = 0; prev_free = 0; found = 0;
        lim = want + want / 2;
        where = 0;
        if (!touched) return 0;
        while (c + 1 < heap_len) begin
            s = size_at(c);
            if (!used_at(c)) begin
                if (have_prev && prev_free) begin
                    s = (c - prev) + s;
                    put_hdr(prev, s, 0);
                    c = prev;
                end else begin
                    if (s >= want && s < best_sz) begin
                        best = c; best_sz = s; found = 1;
                        if (s <= lim) begin
                            where = best;
                            return 1;
                        end
                    end
                    prev = c; prev_free = 1; have_prev = 1;
                end
            end else begin
                prev = c; prev_free = 0; have_prev = 1;
            end
            c = rnd8(c + s + 9);
        end
        where = best;
        return found;
    endfunction

    function automatic t_answer predict_allocation(int unsigned want);
        t_answer r;
        int unsigned c, whole, fin, nxt, pad;
        bit got;
        r = '0;
        got = find_fit(want, c);
        if (got) begin
            whole = size_at(c);
            fin = c + 9 + want;
            nxt = rnd8(fin);
            pad = nxt - fin;
            if (whole > want + 9 + pad + 9) begin
                put_hdr(c, want, 1);
                put_hdr(nxt, whole - want - 9 - pad, 0);
            end else begin
                put_hdr(c, whole, 1);
            end
        end else begin
            c = rnd8(heap_len);
            if (longint'(c) + want + 9 <= longint'(HEAP_BYTES)) begin
                heap_len = c + want + 9;
                put_hdr(c, want, 1);
                got = 1;
            end
        end
        if (got) begin
            touched = 1;
            r.addr = AddrW'(c + 8);
            r.ok = 1;
        end
        return r;
    endfunction

    function automatic t_answer predict_release(int unsigned addr);
        t_answer r;
        r = '0;
        if (addr != 0 && touched && addr + 1 < heap_len && addr % 8 == 0) begin
            if ((addr - 8) / 8 < SlotCount) hdr_mem[(addr - 8) / 8].used = 1'b0;
            r.ok = 1;
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_answer got_r, exp_r;
        if (!i_rst_n) begin
            heap_len = 0;
            touched = 0;
            answer_q.delete();
            o_pending = 0;
            o_fail_count <= 0;
        end else begin
            if (i_valid) begin
                got_r.addr = i_payload_addr;
                got_r.ok = i_ok;
                if (answer_q.size() == 0) begin
                    $display("%0t: unexpected result addr=%h ok=%b", $realtime,
                             got_r.addr, got_r.ok);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_r = answer_q.pop_front();
                    if (got_r.addr !== exp_r.addr) begin
                        $display("%0t: payload_addr expected %h actual %h", $realtime,
                                 exp_r.addr, got_r.addr);
                        o_fail_count <= o_fail_count + 1;
                    end else if (got_r.ok !== exp_r.ok) begin
                        $display("%0t: ok expected %b actual %b", $realtime,
                                 exp_r.ok, got_r.ok);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            // transaction accepted: predict into the queue
            if (i_start && !i_busy) begin
                case (t_action'(i_action))
                    ACT_INIT: begin
                        touched = 0;
                        answer_q.push_back('0);
                    end
                    ACT_ALLOC:   answer_q.push_back(predict_allocation(i_request_size));
                    ACT_RELEASE: answer_q.push_back(predict_release(i_release_addr));
                    default:     answer_q.push_back('0);
                endcase
            end
            o_pending = answer_q.size();
        end
    end
endmodule

// File: dv/testbench.sv
`timescale 1ns / 100ps
// stimulus and verdict for the implicit-list heap allocator
// depends on ilha_pkg, implicit_list_heap_allocator and ilha_scoreboard
module testbench;
    import ilha_pkg::*;

    localparam int unsigned CycleLimit = 30_000_000;

    logic              i_clk = 0;
    logic              i_rst_n = 0;
    logic              start = 0;
    logic              busy;
    logic [1:0]        i_action = ACT_NOP;
    logic [ReqW-1:0]   i_request_size = '0;
    logic [AddrW-1:0]  i_release_addr = '0;
    logic              o_valid;
    logic [AddrW-1:0]  o_payload_addr;
    logic              o_ok;
    int unsigned       fail_count, pending;
    int unsigned       cycle_count = 0;
    int unsigned       burst_left = 0;
    logic [AddrW-1:0]  handed_out[$];
    bit                after_init = 0;

    always begin
        #2 i_clk = 1;
        #2 i_clk = 0;
    end

    implicit_list_heap_allocator i_dut (
        .i_clk, .i_rst_n, .start, .busy, .i_action, .i_request_size,
        .i_release_addr, .o_valid, .o_payload_addr, .o_ok
    );

    ilha_scoreboard u_checker (
        .i_clk, .i_rst_n, .i_start(start), .i_busy(busy), .i_action,
        .i_request_size, .i_release_addr, .i_valid(o_valid),
        .i_payload_addr(o_payload_addr), .i_ok(o_ok),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // one transaction, then wait for its strobe; addresses handed out are kept for releases
    task automatic issue(t_action act, int unsigned req, int unsigned addr);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            repeat (gap) @(posedge i_clk);
        end
        burst_left--;
        start <= 1;
        i_action <= act;
        i_request_size <= req[ReqW-1:0];
        i_release_addr <= addr[AddrW-1:0];
        do @(posedge i_clk); while (busy);
        start <= 0;
        do @(posedge i_clk); while (!o_valid);
        if (act == ACT_ALLOC && o_ok) handed_out.push_back(o_payload_addr);
        if (act == ACT_INIT) after_init = 1;
        if (act == ACT_ALLOC && o_ok) after_init = 0;
    endtask

    function automatic int unsigned pick_size();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 85) return $urandom_range(0, 200);
        if (r < 98) return $urandom_range(201, 6000);
        return $urandom_range(0, 1) ? 65536 : $urandom_range(60000, 131071);
    endfunction

    function automatic int unsigned pick_release();
        int unsigned r;
        r = $urandom_range(0, 99);
        // before any allocation succeeds after init every release is ignored
        if (after_init) return $urandom_range(0, 65535);
        if (r < 80 && handed_out.size() != 0)
            return handed_out[$urandom_range(0, handed_out.size() - 1)];
        if (r < 90) return 0;
        return ($urandom_range(0, 65535) | 1) ^ ($urandom_range(0, 6) & 6);
    endfunction

    initial begin
        int unsigned r;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: untouched heap, null and odd releases, size extremes, overflow
        issue(ACT_NOP, 0, 0);
        issue(ACT_RELEASE, 0, 16);
        issue(ACT_ALLOC, 65536, 0);
        issue(ACT_ALLOC, 131071, 0);
        issue(ACT_ALLOC, 0, 0);
        issue(ACT_ALLOC, 1, 0);
        issue(ACT_ALLOC, 7, 0);
        issue(ACT_ALLOC, 8, 0);
        issue(ACT_ALLOC, 9, 0);
        issue(ACT_ALLOC, 100, 0);
        issue(ACT_ALLOC, 3, 0);
        issue(ACT_RELEASE, 0, 0);
        issue(ACT_RELEASE, 0, 16'hFFF8);
        issue(ACT_RELEASE, 0, 13);
        issue(ACT_RELEASE, 0, handed_out[5]);
        issue(ACT_RELEASE, 0, handed_out[4]);
        issue(ACT_ALLOC, 10, 0);
        issue(ACT_ALLOC, 50, 0);
        issue(ACT_INIT, 0, 0);
        issue(ACT_RELEASE, 0, 16'hFFFF);
        issue(ACT_ALLOC, 4, 0);
        issue(ACT_ALLOC, 65000, 0);
        issue(ACT_ALLOC, 60000, 0);
        issue(ACT_NOP, 131071, 65535);

        for (int i = 0; i < 850; i++) begin
            r = $urandom_range(0, 99);
            if (r < 52)      issue(ACT_ALLOC, pick_size(), $urandom_range(0, 65535));
            else if (r < 94) issue(ACT_RELEASE, $urandom_range(0, 131071), pick_release());
            else if (r < 97) issue(ACT_INIT, $urandom_range(0, 131071), $urandom_range(0, 65535));
            else             issue(ACT_NOP, $urandom_range(0, 131071), $urandom_range(0, 65535));
        end

        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
